/* rtl/fwe_pkg.sv */
// Shared types, widths and codes for the watermark-event handle queue.
package fwe_pkg;

    localparam int QUEUE_DEPTH  = 256;
    localparam int HANDLE_WIDTH = 32;
    localparam int PTR_W        = $clog2(QUEUE_DEPTH);
    localparam int COUNT_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int HIGH_W       = 9;
    localparam int LOW_W        = 8;
    localparam int STATUS_W     = 2;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 9;
    localparam int STEP_W       = $clog2(COUNT_W + 1);

    typedef enum logic {
        OP_PUSH = 1'b0,
        OP_POP  = 1'b1
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_DONE  = 2'd0,
        STATUS_EMPTY = 2'd1,
        STATUS_FULL  = 2'd2
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_HIGH_MARK = 2'd0,
        REG_LOW_MARK  = 2'd1,
        REG_LOW_EN    = 2'd2
    } cfg_idx_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MOD_WAIT,
        ST_FINISH
    } seq_state_t;

    // Request to the shared remainder unit.
    typedef struct packed {
        logic               start;
        logic [COUNT_W-1:0] dividend;
        logic [HIGH_W-1:0]  divisor;
    } mod_req_t;

    // Answer from the shared remainder unit.
    typedef struct packed {
        logic               done;
        logic [HIGH_W-1:0]  remainder;
    } mod_rsp_t;

endpackage

/* rtl/fwe_if.sv */
// Channel interfaces: input items, result items and configuration writes.
interface fwe_in_if;
    logic                            valid;
    logic                            ready;
    logic                            op;
    logic [fwe_pkg::HANDLE_WIDTH-1:0] msg_handle;

    modport source (output valid, output op, output msg_handle, input ready);
    modport sink   (input valid, input op, input msg_handle, output ready);
endinterface

interface fwe_out_if;
    logic                            valid;
    logic                            ready;
    logic [fwe_pkg::HANDLE_WIDTH-1:0] read_handle;
    logic [fwe_pkg::STATUS_W-1:0]     status;
    logic                            high_event;
    logic                            low_event;
    logic [fwe_pkg::COUNT_W-1:0]      item_count;

    modport source (output valid, output read_handle, output status, output high_event,
                    output low_event, output item_count, input ready);
    modport sink   (input valid, input read_handle, input status, input high_event,
                    input low_event, input item_count, output ready);
    modport mon    (input valid, input ready, input read_handle, input status,
                    input high_event, input low_event, input item_count);
endinterface

interface fwe_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [fwe_pkg::CFG_IDX_W-1:0]  index;
    logic [fwe_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

/* rtl/fwe_store.sv */
// Handle storage memory with one write port and one registered read port.
module fwe_store (
    input  logic                             clk,
    input  logic                             wr_en,
    input  logic [fwe_pkg::PTR_W-1:0]        wr_addr,
    input  logic [fwe_pkg::HANDLE_WIDTH-1:0] wr_data,
    input  logic                             rd_en,
    input  logic [fwe_pkg::PTR_W-1:0]        rd_addr,
    output logic [fwe_pkg::HANDLE_WIDTH-1:0] rd_data
);
    import fwe_pkg::*;

    logic [HANDLE_WIDTH-1:0] mem [QUEUE_DEPTH];
    logic [HANDLE_WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* rtl/fwe_mod_unit.sv */
// Shared remainder unit: restoring division, one quotient bit per cycle.
module fwe_mod_unit (
    input  logic              clk,
    input  logic              rst_n,
    input  fwe_pkg::mod_req_t req,
    output fwe_pkg::mod_rsp_t rsp
);
    import fwe_pkg::*;

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic [HIGH_W-1:0]   rem_reg, rem_next;
    logic [COUNT_W-1:0]  dvd_reg, dvd_next;
    logic [HIGH_W-1:0]   dvs_reg, dvs_next;
    logic [HIGH_W:0]     trial;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvd_reg <= dvd_next;
        dvs_reg <= dvs_next;
    end

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        rem_next  = rem_reg;
        dvd_next  = dvd_reg;
        dvs_next  = dvs_reg;
        trial     = {rem_reg, dvd_reg[COUNT_W-1]};
        if (req.start)
        begin
            busy_next = 1'b1;
            step_next = '0;
            rem_next  = '0;
            dvd_next  = req.dividend;
            dvs_next  = req.divisor;
        end
        else if (busy_reg)
        begin
            // The partial remainder stays below the divisor, so it fits HIGH_W bits.
            if (trial >= {1'b0, dvs_reg})
            begin
                rem_next = HIGH_W'(trial - {1'b0, dvs_reg});
            end
            else
            begin
                rem_next = HIGH_W'(trial);
            end
            dvd_next  = {dvd_reg[COUNT_W-2:0], 1'b0};
            step_next = step_reg + 1'b1;
            if (step_reg == STEP_W'(COUNT_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    assign rsp.done      = done_reg;
    assign rsp.remainder = rem_reg;

endmodule

/* rtl/fifo_with_watermark_events.sv */
// Top level of the handle queue with programmable watermark events.
//
// Items arrive on in_ch: op selects a push of msg_handle or a non-blocking pop of
// the oldest handle. Every item yields exactly one result item on out_ch, carrying
// the popped handle (zero when nothing was popped), a status code, the high and
// low watermark events and the number of handles held afterwards.
// cfg_ch writes the high mark, the low mark and the low event enable, and is
// always ready; it is meant to be written only while the queue is idle.
// With no watermark test (high mark zero, low event settings off on a pop, queue
// full or empty) the sequencer goes straight from idle to ST_FINISH, which loads
// the result into the output register and returns to idle. Otherwise the count
// modulo the high mark goes through a shared restoring divider, one quotient bit
// per cycle over the 9-bit count, in ST_MOD_WAIT before ST_FINISH loads the
// result. The input is ready only when idle.
// Results sit in an output register, so the next item can be accepted while
// a result still waits; a stalled receiver holds the sequencer in its final
// state until that register frees up.
// Reset clears the pointers, the count, the peak and all configuration
// registers; the handle memory is not cleared and is read only where written.
module fifo_with_watermark_events (
    input  logic      clk,
    input  logic      rst_n,
    fwe_in_if.sink    in_ch,
    fwe_out_if.source out_ch,
    fwe_cfg_if.sink   cfg_ch
);
    import fwe_pkg::*;

    // Configuration.
    logic [HIGH_W-1:0]       high_mark_reg;
    logic [LOW_W-1:0]        low_mark_reg;
    logic                    low_en_reg;

    // Queue state.
    logic [PTR_W-1:0]        head_reg, head_next;
    logic [PTR_W-1:0]        tail_reg, tail_next;
    logic [COUNT_W-1:0]      count_reg, count_next;
    logic [COUNT_W-1:0]      peak_reg, peak_next;

    // Sequencer and the item in flight.
    seq_state_t              state_reg, state_next;
    logic                    is_pop_reg, is_pop_next;
    logic [STATUS_W-1:0]     status_reg, status_next;
    logic                    hev_reg, hev_next;
    logic                    lev_reg, lev_next;

    // Output register.
    logic                    out_valid_reg, out_valid_next;
    logic [HANDLE_WIDTH-1:0] out_handle_reg, out_handle_next;
    logic [STATUS_W-1:0]     out_status_reg, out_status_next;
    logic                    out_hev_reg, out_hev_next;
    logic                    out_lev_reg, out_lev_next;
    logic [COUNT_W-1:0]      out_count_reg, out_count_next;

    logic                    in_accept;
    logic                    queue_full;
    logic                    queue_empty;
    logic                    mem_wr_en;
    logic                    mem_rd_en;
    logic [HANDLE_WIDTH-1:0] mem_rd_data;
    mod_req_t                mod_req;
    mod_rsp_t                mod_rsp;

    fwe_store u_store (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (tail_reg),
        .wr_data (in_ch.msg_handle),
        .rd_en   (mem_rd_en),
        .rd_addr (head_reg),
        .rd_data (mem_rd_data)
    );

    fwe_mod_unit u_mod (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mod_req),
        .rsp   (mod_rsp)
    );

    // Configuration writes; indexes past the register list are dropped.
    assign cfg_ch.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            high_mark_reg <= '0;
            low_mark_reg  <= '0;
            low_en_reg    <= 1'b0;
        end
        else if (cfg_ch.valid)
        begin
            case (cfg_ch.index)
                REG_HIGH_MARK: high_mark_reg <= cfg_ch.data[HIGH_W-1:0];
                REG_LOW_MARK:  low_mark_reg  <= cfg_ch.data[LOW_W-1:0];
                REG_LOW_EN:    low_en_reg    <= cfg_ch.data[0];
                default:       ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            peak_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            count_reg     <= count_next;
            peak_reg      <= peak_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        is_pop_reg     <= is_pop_next;
        status_reg     <= status_next;
        hev_reg        <= hev_next;
        lev_reg        <= lev_next;
        out_handle_reg <= out_handle_next;
        out_status_reg <= out_status_next;
        out_hev_reg    <= out_hev_next;
        out_lev_reg    <= out_lev_next;
        out_count_reg  <= out_count_next;
    end

    assign queue_full  = (count_reg == COUNT_W'(QUEUE_DEPTH));
    assign queue_empty = (count_reg == '0);
    assign in_ch.ready = (state_reg == ST_IDLE);
    assign in_accept   = in_ch.valid && in_ch.ready;

    always_comb
    begin
        state_next      = state_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        count_next      = count_reg;
        peak_next       = peak_reg;
        is_pop_next     = is_pop_reg;
        status_next     = status_reg;
        hev_next        = hev_reg;
        lev_next        = lev_reg;
        out_valid_next  = out_valid_reg && !out_ch.ready;
        out_handle_next = out_handle_reg;
        out_status_next = out_status_reg;
        out_hev_next    = out_hev_reg;
        out_lev_next    = out_lev_reg;
        out_count_next  = out_count_reg;
        mem_wr_en       = 1'b0;
        mem_rd_en       = 1'b0;
        mod_req.start    = 1'b0;
        mod_req.dividend = '0;
        mod_req.divisor  = high_mark_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    is_pop_next = (in_ch.op == OP_POP);
                    status_next = STATUS_DONE;
                    hev_next    = 1'b0;
                    lev_next    = 1'b0;
                    state_next  = ST_FINISH;
                    if (in_ch.op == OP_PUSH)
                    begin
                        if (queue_full)
                        begin
                            status_next = STATUS_FULL;
                        end
                        else
                        begin
                            mem_wr_en  = 1'b1;
                            tail_next  = (tail_reg == PTR_W'(QUEUE_DEPTH - 1)) ?
                                         '0 : tail_reg + 1'b1;
                            count_next = count_reg + 1'b1;
                            if (high_mark_reg != '0)
                            begin
                                mod_req.start    = 1'b1;
                                mod_req.dividend = count_next;
                                state_next       = ST_MOD_WAIT;
                            end
                        end
                    end
                    else
                    begin
                        if (queue_empty)
                        begin
                            status_next = STATUS_EMPTY;
                        end
                        else
                        begin
                            mem_rd_en  = 1'b1;
                            head_next  = (head_reg == PTR_W'(QUEUE_DEPTH - 1)) ?
                                         '0 : head_reg + 1'b1;
                            count_next = count_reg - 1'b1;
                            if (high_mark_reg != '0 && low_mark_reg != '0 && low_en_reg)
                            begin
                                mod_req.start    = 1'b1;
                                mod_req.dividend = count_next;
                                state_next       = ST_MOD_WAIT;
                            end
                        end
                    end
                end
            end

            ST_MOD_WAIT:
            begin
                if (mod_rsp.done)
                begin
                    state_next = ST_FINISH;
                    if (!is_pop_reg)
                    begin
                        if (mod_rsp.remainder == '0)
                        begin
                            hev_next  = 1'b1;
                            peak_next = count_reg;
                        end
                    end
                    else if (mod_rsp.remainder == HIGH_W'(low_mark_reg) &&
                             peak_reg > count_reg)
                    begin
                        lev_next  = 1'b1;
                        // The peak saturates at zero when the high mark was raised.
                        peak_next = (peak_reg > COUNT_W'(high_mark_reg)) ?
                                    peak_reg - COUNT_W'(high_mark_reg) : '0;
                    end
                end
            end

            ST_FINISH:
            begin
                if (!out_valid_reg || out_ch.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_handle_next = (is_pop_reg && status_reg == STATUS_DONE) ?
                                      mem_rd_data : '0;
                    out_status_next = status_reg;
                    out_hev_next    = hev_reg;
                    out_lev_next    = lev_reg;
                    out_count_next  = count_reg;
                    state_next      = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_ch.valid       = out_valid_reg;
    assign out_ch.read_handle = out_handle_reg;
    assign out_ch.status      = out_status_reg;
    assign out_ch.high_event  = out_hev_reg;
    assign out_ch.low_event   = out_lev_reg;
    assign out_ch.item_count  = out_count_reg;

endmodule

/* rtl/fwe_checker.sv */
// Port-level checks on the result channel of the handle queue, bound to the top level.
module fwe_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             valid,
    input logic                             ready,
    input logic [fwe_pkg::HANDLE_WIDTH-1:0] read_handle,
    input logic [fwe_pkg::STATUS_W-1:0]     status,
    input logic                             high_event,
    input logic                             low_event,
    input logic [fwe_pkg::COUNT_W-1:0]      item_count
);
    import fwe_pkg::*;

    // A stalled result stays offered.
    assert property (@(posedge clk) disable iff (!rst_n)
        valid && !ready |=> valid)
        else $error("result dropped while stalled");

    // The count never exceeds the depth.
    assert property (@(posedge clk) disable iff (!rst_n)
        valid |-> item_count <= COUNT_W'(QUEUE_DEPTH))
        else $error("item count above queue depth");

    // A rejected push or empty pop raises no event.
    assert property (@(posedge clk) disable iff (!rst_n)
        valid && status != STATUS_DONE |->
        !high_event && !low_event)
        else $error("event on a rejected item");

    // A pop on an empty queue returns a zero handle and an empty count.
    assert property (@(posedge clk) disable iff (!rst_n)
        valid && status == STATUS_EMPTY |->
        read_handle == '0 && item_count == '0)
        else $error("empty pop with data or non-zero count");

    // The two events never come from one item.
    assert property (@(posedge clk) disable iff (!rst_n)
        valid |-> !(high_event && low_event))
        else $error("high and low event together");

endmodule

bind fifo_with_watermark_events fwe_checker u_fwe_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .valid       (out_ch.valid),
    .ready       (out_ch.ready),
    .read_handle (out_ch.read_handle),
    .status      (out_ch.status),
    .high_event  (out_ch.high_event),
    .low_event   (out_ch.low_event),
    .item_count  (out_ch.item_count)
);

/* bench/tb_top.sv */
// Self-checking testbench for the handle queue with programmable watermark events.
module tb_top;
    import fwe_pkg::*;

    // Fixed pause before configuration writes; it outlasts the slowest item, one that goes through the divider.
    localparam int SETTLE_CYCLES  = 16;
    // Cycles allowed after the last result for stray result items to show up.
    localparam int DRAIN_CYCLES   = 30;
    // Length of the one long receiver stall that backs the queue up to its input.
    localparam int LONG_HOLD      = 300;
    // Cycles with no handshake on any channel before the run is declared hung.
    localparam int WATCHDOG_LIMIT = 4000;
    // Register index that decodes to nothing; a write there must change nothing.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

    // One queue operation waiting to be offered to the block.
    typedef struct {
        op_t                     op;
        logic [HANDLE_WIDTH-1:0] handle;
    } queue_op_t;

    // The result item that one operation is predicted to produce.
    typedef struct {
        logic [HANDLE_WIDTH-1:0] read_handle;
        status_t                 status;
        logic                    high_event;
        logic                    low_event;
        logic [COUNT_W-1:0]      item_count;
    } queue_result_t;

    logic clk;
    logic rst_n;

    fwe_in_if  in_ch ();
    fwe_out_if out_ch ();
    fwe_cfg_if cfg_ch ();

    fifo_with_watermark_events uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch),
        .cfg_ch (cfg_ch)
    );

    // Operations not yet accepted by the block, oldest first. The initial block
    // appends whole phases at once and the driver consumes them.
    queue_op_t     pending_items[$];
    // Predicted result items, oldest first, appended when an item is accepted.
    queue_result_t expected_results[$];

    // Shadow of the block: the handles it holds, the recorded peak and the
    // three configuration registers as they were last written.
    logic [HANDLE_WIDTH-1:0] held_handles[$];
    int                      peak_level   = 0;
    logic [HIGH_W-1:0]       high_step    = '0;
    logic [LOW_W-1:0]        low_residue  = '0;
    logic                    low_watch_en = 1'b0;

    // Fill level that the generator expects, used only to shape the traffic.
    int plan_fill   = 0;
    int error_count = 0;
    int send_gap    = 0;
    int stall_left  = 0;
    int idle_cycles = 0;
    // When set, neither side takes random gaps, giving back-to-back stretches.
    bit steady_stream    = 1'b0;
    // Set by the stimulus to ask the receiver for one long stall.
    bit hold_off_pending = 1'b0;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Gap length for either side: mostly none or short, now and then long.
    function automatic int pick_gap(bit steady);
        int roll;
        roll = $urandom_range(0, 99);
        if (steady || roll < 50)
            return 0;
        if (roll < 85)
            return $urandom_range(1, 3);
        if (roll < 97)
            return $urandom_range(4, 14);
        return $urandom_range(20, 60);
    endfunction

    // Applies one accepted operation to the shadow queue and returns the result
    // item the block must produce for it. A push raises the high event when the
    // new count is a multiple of the high mark and records the count as the peak.
    // A pop raises the low event, if enabled and the low mark is not zero, when the
    // count modulo the high mark equals the low mark and the peak is still above the
    // count; the peak then drops by the high mark but never below zero, which matters
    // after the high mark has been raised while a large peak was recorded.
    function automatic queue_result_t advance_queue(op_t op,
                                                    logic [HANDLE_WIDTH-1:0] handle);
        queue_result_t r;
        int            fill;
        r.read_handle = '0;
        r.status      = STATUS_DONE;
        r.high_event  = 1'b0;
        r.low_event   = 1'b0;
        if (op == OP_PUSH)
        begin
            if (held_handles.size() >= QUEUE_DEPTH)
                r.status = STATUS_FULL;
            else
            begin
                held_handles.push_back(handle);
                fill = held_handles.size();
                if (high_step != 0 && fill % int'(high_step) == 0)
                begin
                    r.high_event = 1'b1;
                    peak_level   = fill;
                end
            end
        end
        else if (held_handles.size() == 0)
            r.status = STATUS_EMPTY;
        else
        begin
            r.read_handle = held_handles.pop_front();
            fill          = held_handles.size();
            if (high_step != 0 && low_residue != 0 && low_watch_en &&
                fill % int'(high_step) == int'(low_residue) && peak_level > fill)
            begin
                r.low_event = 1'b1;
                peak_level  = (peak_level > int'(high_step)) ?
                              peak_level - int'(high_step) : 0;
            end
        end
        r.item_count = COUNT_W'(held_handles.size());
        return r;
    endfunction

    function automatic void queue_push(logic [HANDLE_WIDTH-1:0] handle);
        pending_items.push_back('{op: OP_PUSH, handle: handle});
        if (plan_fill < QUEUE_DEPTH)
            plan_fill++;
    endfunction

    // The handle of a pop is random; the block must ignore it.
    function automatic void queue_pop();
        pending_items.push_back('{op: OP_POP, handle: $urandom()});
        if (plan_fill > 0)
            plan_fill--;
    endfunction

    // Waits until every queued item has been accepted and every result checked.
    task automatic wait_drained();
        while (pending_items.size() != 0 || expected_results.size() != 0)
            @(posedge clk);
    endtask

    // One write on the configuration channel; the shadow registers follow the
    // same masking as the block, and an unknown index changes nothing.
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        @(posedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do
            @(posedge clk);
        while (cfg_ch.ready !== 1'b1);
        cfg_ch.valid <= 1'b0;
        case (idx)
            REG_HIGH_MARK: high_step    = value[HIGH_W-1:0];
            REG_LOW_MARK:  low_residue  = value[LOW_W-1:0];
            REG_LOW_EN:    low_watch_en = value[0];
            default: ;
        endcase
    endtask

    // New settings are only written once the block has gone idle. Every item
    // yields a result, so an empty expectation list means nothing is in flight;
    // the short pause covers the block's own pipeline anyway.
    task automatic set_marks(logic [CFG_DATA_W-1:0] hm, logic [CFG_DATA_W-1:0] lm,
                             logic [CFG_DATA_W-1:0] en);
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        write_reg(REG_HIGH_MARK, hm);
        write_reg(REG_LOW_MARK, lm);
        write_reg(REG_LOW_EN, en);
    endtask

    // Random traffic built from runs of pushes and runs of pops, so that the count
    // climbs through and falls back across the watermarks. The direction leans
    // toward pushes near empty and pops near full; about one run in ten is a
    // random mix, and runs of pops longer than the fill give pops on empty.
    task automatic add_traffic(int n_items, int max_run);
        int left;
        int run;
        int roll;
        bit pushing;
        left = n_items;
        while (left > 0)
        begin
            run = $urandom_range(1, max_run);
            if (run > left)
                run = left;
            roll = $urandom_range(0, 9);
            if (plan_fill < 4)
                pushing = 1'b1;
            else if (plan_fill > QUEUE_DEPTH - 6)
                pushing = 1'b0;
            else
                pushing = $urandom_range(0, 1);
            repeat (run)
            begin
                if (roll == 0)
                    pushing = $urandom_range(0, 1);
                if (pushing)
                    queue_push($urandom());
                else
                    queue_pop();
            end
            left -= run;
        end
    endtask

    // Driver: offers the oldest pending item and holds it until accepted. The
    // prediction is made at the accepting edge, so the expected results follow
    // the exact order in which the block took the items.
    always @(posedge clk)
    begin : item_driver
        bit accepted;
        if (!rst_n)
        begin
            in_ch.valid <= 1'b0;
            send_gap = 0;
        end
        else
        begin
            accepted = in_ch.valid && in_ch.ready;
            if (accepted)
            begin
                expected_results.push_back(advance_queue(pending_items[0].op,
                                                         pending_items[0].handle));
                pending_items.delete(0);
                send_gap = pick_gap(steady_stream);
            end
            // A new item is only put up once the previous one is gone.
            if (accepted || !in_ch.valid)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    in_ch.valid <= 1'b0;
                end
                else if (pending_items.size() > 0)
                begin
                    in_ch.valid      <= 1'b1;
                    in_ch.op         <= pending_items[0].op;
                    in_ch.msg_handle <= pending_items[0].handle;
                end
                else
                    in_ch.valid <= 1'b0;
            end
        end
    end

    // Receiver: after each result item it may stall for a random gap. On request
    // it stalls once for a long stretch, which fills the output register, parks
    // the sequencer and makes the block refuse further items for a while.
    always @(posedge clk)
    begin : result_receiver
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (hold_off_pending)
            begin
                hold_off_pending = 1'b0;
                stall_left       = LONG_HOLD;
            end
            else if (out_ch.valid && out_ch.ready)
                stall_left = pick_gap(steady_stream);
            if (stall_left > 0)
            begin
                stall_left--;
                out_ch.ready <= 1'b0;
            end
            else
                out_ch.ready <= 1'b1;
        end
    end

    // Monitor: every accepted result item is compared with the oldest prediction.
    always @(posedge clk)
    begin : result_monitor
        queue_result_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (expected_results.size() == 0)
            begin
                error_count++;
                $error("result item with no expectation waiting: item_count %0d",
                       out_ch.item_count);
            end
            else
            begin
                want = expected_results.pop_front();
                if (out_ch.read_handle !== want.read_handle)
                begin
                    error_count++;
                    $error("read_handle: expected %h, actual %h",
                           want.read_handle, out_ch.read_handle);
                end
                if (out_ch.status !== want.status)
                begin
                    error_count++;
                    $error("status: expected %0d, actual %0d", want.status, out_ch.status);
                end
                if (out_ch.high_event !== want.high_event)
                begin
                    error_count++;
                    $error("high_event: expected %0b, actual %0b",
                           want.high_event, out_ch.high_event);
                end
                if (out_ch.low_event !== want.low_event)
                begin
                    error_count++;
                    $error("low_event: expected %0b, actual %0b",
                           want.low_event, out_ch.low_event);
                end
                if (out_ch.item_count !== want.item_count)
                begin
                    error_count++;
                    $error("item_count: expected %0d, actual %0d",
                           want.item_count, out_ch.item_count);
                end
            end
        end
    end

    // Watchdog: any handshake on any channel counts as progress.
    always @(posedge clk)
    begin : watchdog
        if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin : stimulus
        int hm;
        int lm;
        int en;
        int roll;

        // Every input of the block is known from time zero.
        in_ch.valid      = 1'b0;
        in_ch.op         = OP_PUSH;
        in_ch.msg_handle = '0;
        out_ch.ready     = 1'b0;
        cfg_ch.valid     = 1'b0;
        cfg_ch.index     = REG_HIGH_MARK;
        cfg_ch.data      = '0;
        rst_n            = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Marks off: plain queueing, pops on an empty queue, extreme handles.
        // A write to the unused index must leave every register alone.
        write_reg(REG_SPARE, 9'h1FF);
        set_marks(9'd0, 9'd0, 9'd0);
        queue_pop();
        queue_push(32'hFFFF_FFFF);
        queue_push(32'h0000_0000);
        queue_push(32'hA5A5_5A5A);
        repeat (4) queue_pop();

        // Small marks, back to back: high events at four and eight, then low
        // events on the way down at five and one, the second taking the peak
        // to zero.
        steady_stream = 1'b1;
        set_marks(9'd4, 9'd1, 9'd1);
        repeat (8) queue_push($urandom());
        repeat (8) queue_pop();

        // High mark equal to the depth and largest low mark: fill the queue completely, push once
        // more onto the full queue, then drain it and pop once on empty. The
        // receiver stalls for a long stretch meanwhile, so the input backs up.
        set_marks(9'd256, 9'd255, 9'd1);
        repeat (QUEUE_DEPTH + 1) queue_push($urandom());
        hold_off_pending = 1'b1;
        repeat (QUEUE_DEPTH + 1) queue_pop();
        steady_stream = 1'b0;

        // Peak saturation: record a peak of sixteen with a high mark of eight,
        // then raise the high mark above the peak so the decrement clamps to zero.
        set_marks(9'd8, 9'd3, 9'd1);
        repeat (16) queue_push($urandom());
        set_marks(9'd100, 9'd3, 9'd1);
        repeat (16) queue_pop();

        // Low mark not below the high mark: the low event can never fire.
        set_marks(9'd6, 9'd8, 9'd1);
        add_traffic(60, 12);

        // High mark above the depth: no push reaches a multiple.
        set_marks(9'd511, 9'd255, 9'd1);
        add_traffic(60, 80);

        // High mark of one fires on every push; low enable off blocks low events.
        set_marks(9'd1, 9'd1, 9'd1);
        add_traffic(40, 12);
        set_marks(9'd3, 9'd1, 9'd0);
        add_traffic(40, 12);

        // Random settings, mostly small marks where the events come often.
        repeat (7)
        begin
            roll          = $urandom_range(0, 9);
            steady_stream = ($urandom_range(0, 4) == 0);
            if (roll < 6)
            begin
                hm = $urandom_range(2, 20);
                lm = $urandom_range(1, hm - 1);
                en = ($urandom_range(0, 4) != 0);
            end
            else if (roll == 6)
            begin
                // Raw nine-bit data: exercises the masking of narrower registers.
                hm = $urandom_range(0, 511);
                lm = $urandom_range(0, 511);
                en = $urandom_range(0, 511);
            end
            else if (roll == 7)
            begin
                hm = 0;
                lm = $urandom_range(1, 255);
                en = 1;
            end
            else if (roll == 8)
            begin
                hm = $urandom_range(21, 64);
                lm = $urandom_range(1, hm - 1);
                en = 1;
            end
            else
            begin
                hm = QUEUE_DEPTH;
                lm = $urandom_range(1, 255);
                en = 1;
            end
            set_marks(hm[CFG_DATA_W-1:0], lm[CFG_DATA_W-1:0], en[CFG_DATA_W-1:0]);
            if ($urandom_range(0, 2) == 0)
                write_reg(REG_SPARE, CFG_DATA_W'($urandom_range(0, 511)));
            add_traffic(90, (hm > 20) ? 80 : 24);
        end
        steady_stream = 1'b0;

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

/* files.f */
rtl/fwe_pkg.sv
rtl/fwe_if.sv
rtl/fwe_store.sv
rtl/fwe_mod_unit.sv
rtl/fifo_with_watermark_events.sv
rtl/fwe_checker.sv
bench/tb_top.sv
